[rtl/counting_semaphore_fifo_waiters_unit_assert.svh]
// Assertion macros used by the checker file of the semaphore unit.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define CSFW_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define CSFW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/csfw_pkg.sv]
// Types, codes and defaults shared by the semaphore unit and its checker.
package csfw_pkg;

   localparam int CountWidth      = 16;
   localparam int IdFieldWidth    = 8;
   localparam int WaitersWidth    = 5;
   localparam int QueueDepthDflt  = 16;
   localparam int IdWidthDflt     = 8;
   localparam int IdWidthMax      = 16;

   typedef logic [CountWidth-1:0] count_type;

   localparam count_type CountMax   = {CountWidth{1'b1}};
   localparam count_type CountReset = count_type'(1);

   typedef enum logic {
      ActAcquire = 1'b0,
      ActRelease = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      StGranted     = 3'd0,
      StBlocked     = 3'd1,
      StIncremented = 3'd2,
      StWoken       = 3'd3,
      StRefused     = 3'd4
   } status_type;

   typedef struct packed {
      action_type              action;
      logic [IdFieldWidth-1:0] requester_id;
   } req_payload_type;

   typedef struct packed {
      status_type              status;
      logic [IdFieldWidth-1:0] woken_id;
      count_type               count_now;
      logic [WaitersWidth-1:0] waiters_now;
   } rsp_payload_type;

endpackage

[rtl/csfw_chan_if.sv]
// Valid/ready channel interface used for the request, response and CSR channels.
interface csfw_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/csfw_waiter_ram.sv]
// Waiter id memory: one write port, one read port with registered read data.
module csfw_waiter_ram #(
   parameter int DEPTH = csfw_pkg::QueueDepthDflt,
   parameter int WIDTH = csfw_pkg::IdWidthDflt
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/counting_semaphore_fifo_waiters_unit.sv]
// Top level of the counting semaphore with a FIFO of blocked requesters.
//
//   Channel   Direction  Payload                                   Handshake
//   req_chan  in         action, requester_id                      valid/ready
//   rsp_chan  out        status, woken_id, count_now, waiters_now  valid/ready
//   csr_chan  in         initial_count (loads the count at once)   valid/ready
//
// One item is taken per cycle while req_chan.ready is high. Each result goes
// through the pending stage (registered waiter memory read) and the output register.
// Reset is synchronous and active high: the count returns to one, the queue
// empties, and the waiter memory is left as is (entries are read only after
// being written). A stalled response holds in the output register; the stage
// behind it holds one more item, after which req_chan.ready drops.
module counting_semaphore_fifo_waiters_unit #(
   parameter int QUEUE_DEPTH = csfw_pkg::QueueDepthDflt,
   parameter int ID_WIDTH    = csfw_pkg::IdWidthDflt
) (
   input logic        clock,
   input logic        reset,
   csfw_chan_if.sink   req_chan,
   csfw_chan_if.source rsp_chan,
   csfw_chan_if.sink   csr_chan
);

   localparam int PtrWidth  = $clog2(QUEUE_DEPTH);
   localparam int FillWidth = $clog2(QUEUE_DEPTH + 1);
   localparam int IdWide    = csfw_pkg::IdWidthMax;

   localparam logic [PtrWidth-1:0]  PtrLast  = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [FillWidth-1:0] FillFull = FillWidth'(QUEUE_DEPTH);

   // Architectural state of the semaphore.
   csfw_pkg::count_type  count_ff, count_in;
   logic [PtrWidth-1:0]  head_ff, head_in;
   logic [PtrWidth-1:0]  tail_ff, tail_in;
   logic [FillWidth-1:0] fill_ff, fill_in;

   // Stage between acceptance and the output register, waiting on the memory read.
   logic                                pend_valid_ff, pend_valid_in;
   csfw_pkg::status_type                pend_status_ff, status_in;
   csfw_pkg::count_type                 pend_count_ff;
   logic [csfw_pkg::WaitersWidth-1:0]   pend_waiters_ff;

   // Output register.
   logic                      rsp_valid_ff;
   csfw_pkg::rsp_payload_type rsp_payload_ff;

   logic                      req_fire, csr_fire, out_free, pend_move;
   logic                      mem_wr_en, mem_rd_en;
   logic [IdWide-1:0]         id_wide, woken_wide;
   logic [ID_WIDTH-1:0]       mem_rd_data;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign pend_move = pend_valid_ff && out_free;

   // A new item may enter whenever the stage in front of the output register
   // is empty or is handing its item on in this cycle. An offered CSR write
   // goes first, so that an item never sees a count that is being replaced.
   assign req_chan.ready = (!pend_valid_ff || out_free) && !csr_chan.valid;
   assign csr_chan.ready = 1'b1;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;

   // Requester ids are kept to ID_WIDTH bits in the waiter memory.
   assign id_wide = IdWide'(req_chan.payload.requester_id);

   // Decide the outcome of the offered item and the next state. The outcome,
   // the count, the pointers and the fill all depend on the queue; the memory
   // itself is written (on a push) or read (on a pop) at the same edge.
   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      status_in = csfw_pkg::StGranted;
      mem_wr_en = 1'b0;
      mem_rd_en = 1'b0;

      if (req_chan.payload.action == csfw_pkg::ActAcquire) begin
         if (count_ff != '0) begin
            count_in  = count_ff - 1'b1;
            status_in = csfw_pkg::StGranted;
         end else if (fill_ff == FillFull) begin
            status_in = csfw_pkg::StRefused;
         end else begin
            mem_wr_en = req_fire;
            tail_in   = (tail_ff == PtrLast) ? '0 : tail_ff + 1'b1;
            fill_in   = fill_ff + 1'b1;
            status_in = csfw_pkg::StBlocked;
         end
      end else begin
         if (fill_ff != '0) begin
            // The woken waiter takes the released unit: the count stays.
            mem_rd_en = req_fire;
            head_in   = (head_ff == PtrLast) ? '0 : head_ff + 1'b1;
            fill_in   = fill_ff - 1'b1;
            status_in = csfw_pkg::StWoken;
         end else if (count_ff == csfw_pkg::CountMax) begin
            status_in = csfw_pkg::StRefused;
         end else begin
            count_in  = count_ff + 1'b1;
            status_in = csfw_pkg::StIncremented;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= csfw_pkg::CountReset;
         head_ff  <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
      end else if (csr_fire) begin
         // A CSR write reloads the count and leaves the queue alone.
         count_ff <= csr_chan.payload;
      end else if (req_fire) begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
      end
   end

   csfw_waiter_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ID_WIDTH)
   ) u_waiter_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (tail_ff),
      .wr_data (id_wide[ID_WIDTH-1:0]),
      .rd_en   (mem_rd_en),
      .rd_addr (head_ff),
      .rd_data (mem_rd_data)
   );

   assign pend_valid_in = req_fire || (pend_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_status_ff  <= status_in;
         pend_count_ff   <= count_in;
         pend_waiters_ff <= csfw_pkg::WaitersWidth'(fill_in);
      end
   end

   // The read data stays put while the item waits here, since no new item
   // (and so no new read) is taken until this one moves on.
   assign woken_wide = IdWide'(mem_rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_payload_ff.status      <= pend_status_ff;
         rsp_payload_ff.woken_id    <= (pend_status_ff == csfw_pkg::StWoken) ?
                                       woken_wide[csfw_pkg::IdFieldWidth-1:0] : '0;
         rsp_payload_ff.count_now   <= pend_count_ff;
         rsp_payload_ff.waiters_now <= pend_waiters_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

[rtl/csfw_checker.sv]
// Port-level checker for the semaphore unit and its bind to the top level.
`include "counting_semaphore_fifo_waiters_unit_assert.svh"

module csfw_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input csfw_pkg::rsp_payload_type rsp_payload
);

   `CSFW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response changed while stalled")

   `CSFW_ASSERT_IMPLY(a_woken_zero, rsp_valid && rsp_payload.status != csfw_pkg::StWoken, rsp_payload.woken_id == '0, "woken id set on a non-wake result")

   `CSFW_ASSERT_IMPLY(a_refused_count, rsp_valid && rsp_payload.status == csfw_pkg::StRefused, rsp_payload.count_now == '0 || rsp_payload.count_now == csfw_pkg::CountMax, "refusal with count neither empty nor saturated")

   `CSFW_ASSERT_IMPLY(a_incr_nonzero, rsp_valid && rsp_payload.status == csfw_pkg::StIncremented, rsp_payload.count_now != '0, "increment left a zero count")

endmodule

bind counting_semaphore_fifo_waiters_unit csfw_checker u_csfw_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
